### hdl/slt_pkg.sv
// Package for the sorted list table: payload structs, operation and status
// codes, controller states and the command/status bundles between modules.
// No dependencies.
package slt_pkg;

    // Operation codes; any code other than insert and delete searches
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Field widths of the result and of the input value
    localparam int POS_W   = 5;
    localparam int COUNT_W = 6;
    localparam int IN_VAL_W = 16;

    typedef struct packed {
        logic [1:0]          op;
        logic [IN_VAL_W-1:0] value;
    } slt_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] entry_count;
    } slt_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_TOP,
        S_INS_CHK,
        S_SCAN_TOP,
        S_SCAN_CHK,
        S_SHIFT_TOP,
        S_SHIFT_CHK
    } slt_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;         // latch value, set index
        logic       load_top;     // index starts at entry count, else zero
        logic       rd_en;        // read memory
        logic       rd_prev;      // read at index - 1, else at index
        logic       wr_en;        // write memory
        logic       wr_rd_data;   // write data is read data, else value
        logic       wr_prev;      // write at index - 1, else at index
        logic       idx_inc;
        logic       idx_dec;
        logic       pos_load;     // position takes the index
        logic       cnt_inc;
        logic       cnt_dec;
        logic       finish;       // register and strobe the result
        logic [1:0] fin_status;
        logic       fin_pos_zero; // report position zero
    } slt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic idx_zero;
        logic idx_at_count;
        logic rd_le;   // read entry <= value
        logic rd_eq;   // read entry == value
    } slt_stat_t;

endpackage

### hdl/slt_ctrl.sv
// Controller of the sorted list table: walks insert, scan and shift phases.
// Depends on slt_pkg.
module slt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        op,
    input  slt_pkg::slt_stat_t stat,
    output logic              busy,
    output slt_pkg::slt_cmd_t cmd
);

    slt_pkg::slt_state_t state_reg;
    slt_pkg::slt_state_t state_next;
    logic                del_reg;
    logic                del_next;

    logic is_insert;
    logic is_delete;

    assign is_insert = (op == slt_pkg::OP_INSERT);
    assign is_delete = (op == slt_pkg::OP_DELETE);
    assign busy      = (state_reg != slt_pkg::S_IDLE);

    // Hold state and operation kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slt_pkg::S_IDLE;
            del_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            del_reg   <= del_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        del_next   = del_reg;
        unique case (state_reg)
            slt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    del_next = is_delete;
                    if (is_insert)
                    begin
                        if (!stat.full)
                        begin
                            state_next = slt_pkg::S_INS_TOP;
                        end
                    end
                    else
                    begin
                        state_next = slt_pkg::S_SCAN_TOP;
                    end
                end
            end
            slt_pkg::S_INS_TOP:
            begin
                state_next = stat.idx_zero ? slt_pkg::S_IDLE : slt_pkg::S_INS_CHK;
            end
            slt_pkg::S_INS_CHK:
            begin
                state_next = stat.rd_le ? slt_pkg::S_IDLE : slt_pkg::S_INS_TOP;
            end
            slt_pkg::S_SCAN_TOP:
            begin
                state_next = stat.idx_at_count ? slt_pkg::S_IDLE : slt_pkg::S_SCAN_CHK;
            end
            slt_pkg::S_SCAN_CHK:
            begin
                priority if (stat.rd_eq && del_reg)
                    state_next = slt_pkg::S_SHIFT_TOP;
                else if (stat.rd_eq)
                    state_next = slt_pkg::S_IDLE;
                else
                    state_next = slt_pkg::S_SCAN_TOP;
            end
            slt_pkg::S_SHIFT_TOP:
            begin
                state_next = stat.idx_at_count ? slt_pkg::S_IDLE : slt_pkg::S_SHIFT_CHK;
            end
            slt_pkg::S_SHIFT_CHK:
            begin
                state_next = slt_pkg::S_SHIFT_TOP;
            end
            default:
            begin
                state_next = slt_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            slt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    cmd.load_top = is_insert;
                    if (is_insert && stat.full)
                    begin
                        cmd.finish       = 1'b1;
                        cmd.fin_status   = slt_pkg::ST_FULL;
                        cmd.fin_pos_zero = 1'b1;
                    end
                end
            end
            slt_pkg::S_INS_TOP:
            begin
                if (stat.idx_zero)
                begin
                    // Table empty below: value lands at the head
                    cmd.wr_en      = 1'b1;
                    cmd.pos_load   = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    cmd.finish     = 1'b1;
                    cmd.fin_status = slt_pkg::ST_OK;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_prev = 1'b1;
                end
            end
            slt_pkg::S_INS_CHK:
            begin
                cmd.wr_en = 1'b1;
                if (stat.rd_le)
                begin
                    cmd.pos_load   = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    cmd.finish     = 1'b1;
                    cmd.fin_status = slt_pkg::ST_OK;
                end
                else
                begin
                    // Move the larger entry up one slot
                    cmd.wr_rd_data = 1'b1;
                    cmd.idx_dec    = 1'b1;
                end
            end
            slt_pkg::S_SCAN_TOP:
            begin
                if (stat.idx_at_count)
                begin
                    cmd.finish       = 1'b1;
                    cmd.fin_status   = slt_pkg::ST_NOT_FOUND;
                    cmd.fin_pos_zero = 1'b1;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            slt_pkg::S_SCAN_CHK:
            begin
                cmd.idx_inc = 1'b1;
                if (stat.rd_eq)
                begin
                    cmd.pos_load = 1'b1;
                    if (!del_reg)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = slt_pkg::ST_OK;
                    end
                end
            end
            slt_pkg::S_SHIFT_TOP:
            begin
                if (stat.idx_at_count)
                begin
                    cmd.cnt_dec    = 1'b1;
                    cmd.finish     = 1'b1;
                    cmd.fin_status = slt_pkg::ST_OK;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            slt_pkg::S_SHIFT_CHK:
            begin
                // Close the gap: entry moves down one slot
                cmd.wr_en      = 1'b1;
                cmd.wr_rd_data = 1'b1;
                cmd.wr_prev    = 1'b1;
                cmd.idx_inc    = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hdl/slt_dpath.sv
// Datapath of the sorted list table: entry memory, index, count, position
// and result registers. Depends on slt_pkg.
module slt_dpath
#(
    parameter int DEPTH       = 32,
    parameter int VALUE_WIDTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [slt_pkg::IN_VAL_W-1:0] value,
    input  slt_pkg::slt_cmd_t  cmd,
    output slt_pkg::slt_stat_t stat,
    output logic               done,
    output slt_pkg::slt_out_t  result
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    logic [VALUE_WIDTH-1:0] val_reg;
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       idx_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [IDX_W-1:0]       pos_reg;
    logic [IDX_W-1:0]       pos_next;
    logic                   done_reg;
    slt_pkg::slt_out_t      result_reg;

    logic [CNT_W-1:0]       idx_m1;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [IDX_W-1:0]       res_pos;

    assign idx_m1  = idx_reg - CNT_W'(1);
    assign rd_addr = cmd.rd_prev ? idx_m1[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_addr = cmd.wr_prev ? idx_m1[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_data = cmd.wr_rd_data ? rd_data_reg : val_reg;

    // Entry memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Status toward the controller
    assign stat.full         = (count_reg == CNT_W'(DEPTH));
    assign stat.idx_zero     = (idx_reg == '0);
    assign stat.idx_at_count = (idx_reg == count_reg);
    assign stat.rd_le        = (rd_data_reg <= val_reg);
    assign stat.rd_eq        = (rd_data_reg == val_reg);

    // Advance index, count and position
    always_comb
    begin
        idx_next = idx_reg;
        priority if (cmd.load)
            idx_next = cmd.load_top ? count_reg : '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + CNT_W'(1);
        else if (cmd.idx_dec)
            idx_next = idx_m1;
        else
            idx_next = idx_reg;

        count_next = count_reg;
        priority if (cmd.cnt_inc)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.cnt_dec)
            count_next = count_reg - CNT_W'(1);
        else
            count_next = count_reg;

        pos_next = cmd.pos_load ? idx_reg[IDX_W-1:0] : pos_reg;
        res_pos  = cmd.fin_pos_zero ? '0 : pos_next;
    end

    // Hold working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= VALUE_WIDTH'(value);
        end
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        if (cmd.finish)
        begin
            result_reg.status      <= cmd.fin_status;
            result_reg.position    <= slt_pkg::POS_W'(res_pos);
            result_reg.entry_count <= slt_pkg::COUNT_W'(count_next);
        end
    end

    // Control registers: entry count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.finish;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hdl/sorted_list_table.sv
// Sorted list table: up to DEPTH unsigned values kept in ascending order.
// Top level; depends on slt_pkg, slt_ctrl and slt_dpath.
//
// Usage:
//   Drive cmd (op, value) and raise start; the item is taken at an edge with
//   start high and busy low. op 0 inserts after equal entries (status full
//   if the table is full), op 1 deletes the first equal entry, op 2 or 3
//   searches; absent values give status not found. position is the index
//   of the new, removed or found entry; entry_count is the count afterward.
//   Each item gives one result on result, marked by done high for exactly
//   one cycle. The receiver cannot stall; done is a pure strobe.
// Steps:
//   insert into a full table: result registered at acceptance, no memory access.
//   otherwise each visited entry is read into the registered read data of
//   the entry memory, then compared with the value; insert walks down from
//   the top, search and delete walk up from the head, and delete then moves
//   each later entry down one slot.
//   busy drops in the cycle that done is high, so the next item may start.
// Reset clears the entry count and the controller; memory contents are
// left as they are and are never read before being written.
module sorted_list_table
#(
    parameter int DEPTH       = 32,
    parameter int VALUE_WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  slt_pkg::slt_in_t  cmd,
    output logic              busy,
    output logic              done,
    output slt_pkg::slt_out_t result
);

    slt_pkg::slt_cmd_t  dp_cmd;
    slt_pkg::slt_stat_t dp_stat;

    // Sequence the operation
    slt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (cmd.op),
        .stat  (dp_stat),
        .busy  (busy),
        .cmd   (dp_cmd)
    );

    // Hold entries and build the result
    slt_dpath
    #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    )
    u_dpath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (cmd.value),
        .cmd    (dp_cmd),
        .stat   (dp_stat),
        .done   (done),
        .result (result)
    );

endmodule
